/* rtl/core/lzssrd_pkg.sv */
// ----------------------------------------------------------------------------
// lzssrd_pkg
// Shared types and constants for the LZSS ring decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lzssrd_pkg;

  localparam int unsigned RING_SIZE = 4096;
  localparam int unsigned RING_AW   = $clog2(RING_SIZE);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned RUN_W      = 5;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_MATCH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD = CFG_IDX_W'(1);

  localparam logic [1:0]  MIN_MATCH_RESET = 2'd2;
  localparam logic [1:0]  MIN_MATCH_MAX   = 2'd2;
  localparam int unsigned LOOKAHEAD_RESET = 18;

  localparam logic [RING_AW-1:0] WP_RESET  = RING_AW'(RING_SIZE - LOOKAHEAD_RESET);
  localparam logic [7:0]         FILL_BYTE = 8'h20;
  localparam logic [7:0]         FLAG_MARK = 8'hff;

  typedef enum logic [1:0] {
    PH_FLAG       = 2'd0,
    PH_TOKEN      = 2'd1,
    PH_MATCH_HIGH = 2'd2
  } phase_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_COPY = 1'b1
  } state_e;

  typedef struct packed {
    logic               rd_en;
    logic [RING_AW-1:0] rd_addr;
    logic               wr_en;
    logic [RING_AW-1:0] wr_addr;
    logic [7:0]         wr_data;
  } ring_req_t;

endpackage

`default_nettype wire

/* rtl/core/lzssrd_ring.sv */
// ----------------------------------------------------------------------------
// lzssrd_ring
// History ring: one write and one read port, registered read with
// same-cycle write forwarding, and a clearing pass to spaces after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lzssrd_ring
  import lzssrd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ring_req_t  req_i,
  output logic [7:0]      rd_data_o,
  output logic            ready_o
);

  logic [7:0]         mem_q [RING_SIZE];
  logic [7:0]         rd_q;
  logic [7:0]         fwd_data_q;
  logic               fwd_hit_q, fwd_hit_d;
  logic               clr_busy_q, clr_busy_d;
  logic [RING_AW-1:0] clr_addr_q, clr_addr_d;

  logic               we;
  logic [RING_AW-1:0] wa;
  logic [7:0]         wd;

  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + RING_AW'(1);
      if (clr_addr_q == {RING_AW{1'b1}}) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_comb begin
    we = clr_busy_q | req_i.wr_en;
    wa = clr_busy_q ? clr_addr_q : req_i.wr_addr;
    wd = clr_busy_q ? FILL_BYTE : req_i.wr_data;
    fwd_hit_d = req_i.rd_en & req_i.wr_en & (req_i.rd_addr == req_i.wr_addr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      fwd_hit_q  <= 1'b0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
      fwd_hit_q  <= fwd_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr];
    end
    fwd_data_q <= req_i.wr_data;
  end

  assign rd_data_o = fwd_hit_q ? fwd_data_q : rd_q;
  assign ready_o   = ~clr_busy_q;

endmodule

`default_nettype wire

/* rtl/core/lzss_ring_decoder_unit.sv */
// ----------------------------------------------------------------------------
// lzss_ring_decoder_unit
// LZSS decoder over a 4096-byte history ring: flag, literal and match bytes
// in, decoded bytes out.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   in      | in_valid_i, in_stall_o, in_byte_i         | in
//   out     | out_valid_o, out_stall_i, out_byte_o,     | out
//           | last_of_run_o                             |
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,    | in
//           | cfg_data_i                                |
//
// Flag and match low bytes are just stored; a literal byte is written to the
// ring and the output queue as it is taken. A match high byte starts a copy of
// count bytes (count = length + threshold + 1, at most 18), one ring read per
// cycle through the single read port of the ring while the output queue has
// room. After reset the ring is cleared to spaces; no input word is taken until
// then. A stalled output holds back further ring reads via a two-word output queue; copying resumes once it has room.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_ring_decoder_unit
  import lzssrd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            in_byte_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic                       last_of_run_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e             state_q, state_d;
  phase_e             phase_q, phase_d;
  logic [15:0]        flag_q, flag_d;
  logic [7:0]         low_q, low_d;
  logic [RING_AW-1:0] wp_q, wp_d;
  logic [1:0]         mm_q, mm_d;
  logic [RING_AW-1:0] rd_addr_q, rd_addr_d;
  logic [RUN_W-1:0]   remain_q, remain_d;
  logic               pend_q, pend_d;
  logic               pend_last_q, pend_last_d;

  logic [7:0]         fifo_data_q [2];
  logic               fifo_last_q [2];
  logic               rptr_q, rptr_d, wptr_q, wptr_d;
  logic [1:0]         cnt_q, cnt_d;

  ring_req_t          ring_req;
  logic [7:0]         ring_rdata;
  logic               ring_rdy;

  logic               pop, in_acc, cfg_acc;
  logic               can_issue, issue, start_copy;
  logic               push, push_last;
  logic [7:0]         push_data;
  logic               lit_wr;
  logic [2:0]         occ;
  logic [1:0]         thr;
  logic [RUN_W-1:0]   run_len;

  lzssrd_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ring_req),
    .rd_data_o (ring_rdata),
    .ready_o   (ring_rdy)
  );

  assign pop         = out_valid_o & ~out_stall_i;
  assign in_stall_o  = ~(ring_rdy & (state_q == ST_IDLE) & ~pend_q &
                         ((cnt_q != 2'd2) | pop));
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  assign occ        = 3'(cnt_q) + 3'(pend_q) - 3'(pop);
  assign can_issue  = (occ < 3'd2);
  assign issue      = (state_q == ST_COPY) & can_issue;
  assign start_copy = in_acc & (phase_q == PH_MATCH_HIGH);

  assign thr     = (mm_q > MIN_MATCH_MAX) ? MIN_MATCH_MAX : mm_q;
  assign run_len = RUN_W'(in_byte_i[3:0]) + RUN_W'(thr) + RUN_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_copy) begin
          state_d = ST_COPY;
        end
      end
      ST_COPY: begin
        if (issue && (remain_q == RUN_W'(1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // token decode, copy control, ring port
  always_comb begin
    phase_d     = phase_q;
    flag_d      = flag_q;
    low_d       = low_q;
    mm_d        = mm_q;
    rd_addr_d   = rd_addr_q;
    remain_d    = remain_q;
    pend_d      = issue;
    pend_last_d = issue & (remain_q == RUN_W'(1));
    lit_wr      = 1'b0;

    if (in_acc) begin
      case (phase_q)
        PH_TOKEN: begin
          if (flag_q[0]) begin
            lit_wr  = 1'b1;
            flag_d  = flag_q >> 1;
            phase_d = flag_q[9] ? PH_TOKEN : PH_FLAG;
          end else begin
            low_d   = in_byte_i;
            phase_d = PH_MATCH_HIGH;
          end
        end
        PH_MATCH_HIGH: begin
          rd_addr_d = {in_byte_i[7:4], low_q};
          remain_d  = run_len;
          flag_d    = flag_q >> 1;
          phase_d   = flag_q[9] ? PH_TOKEN : PH_FLAG;
        end
        default: begin
          flag_d  = {FLAG_MARK, in_byte_i};
          phase_d = PH_TOKEN;
        end
      endcase
    end

    if (issue) begin
      rd_addr_d = rd_addr_q + RING_AW'(1);
      remain_d  = remain_q - RUN_W'(1);
    end

    push      = lit_wr | pend_q;
    push_data = lit_wr ? in_byte_i : ring_rdata;
    push_last = lit_wr | pend_last_q;

    ring_req.rd_en   = issue;
    ring_req.rd_addr = rd_addr_q;
    ring_req.wr_en   = push;
    ring_req.wr_addr = wp_q;
    ring_req.wr_data = push_data;

    wp_d = push ? (wp_q + RING_AW'(1)) : wp_q;
    if (cfg_acc) begin
      if (cfg_index_i == REG_MIN_MATCH) begin
        mm_d = cfg_data_i[1:0];
      end else if (cfg_index_i == REG_LOOKAHEAD) begin
        wp_d = RING_AW'((RING_AW+1)'(RING_SIZE) - (RING_AW+1)'(cfg_data_i));
      end
    end

    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FLAG;
      flag_q      <= '0;
      low_q       <= '0;
      wp_q        <= WP_RESET;
      mm_q        <= MIN_MATCH_RESET;
      remain_q    <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      rptr_q      <= 1'b0;
      wptr_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      flag_q      <= flag_d;
      low_q       <= low_d;
      wp_q        <= wp_d;
      mm_q        <= mm_d;
      remain_q    <= remain_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      rptr_q      <= rptr_d;
      wptr_q      <= wptr_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    if (push) begin
      fifo_data_q[wptr_q] <= push_data;
      fifo_last_q[wptr_q] <= push_last;
    end
  end

  assign out_valid_o   = (cnt_q != 2'd0);
  assign out_byte_o    = fifo_data_q[rptr_q];
  assign last_of_run_o = fifo_last_q[rptr_q];

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("output queue overflow");

  a_no_accept_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!pend_q && state_q == ST_IDLE))
    else $error("input taken while a copy is in flight");

  a_copy_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) |-> (remain_q != '0))
    else $error("copy with nothing left to read");

  a_return_follows_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> pend_q)
    else $error("ring read lost");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && cnt_q == 2'd2) |-> pop)
    else $error("push into full output queue");

endmodule

`default_nettype wire
